### rtl/core/assert_macros.svh
// Assertion macros used by the checker file kpvf_chk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define KPVF_ASSERT_HOLD(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// Check that a cause is followed by an effect in the next cycle.
`define KPVF_ASSERT_NEXT(lbl, cause, effect, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cause) |=> (effect)) else $error(msg);

`endif

### rtl/core/kpvf_pkg.sv
package kpvf_pkg;

    // Width of the time step field
    localparam int TSW = 20;

    // Microcode length and program counter width
    localparam int UC_STEPS = 36;
    localparam int PCW      = 6;
    localparam logic [PCW-1:0] UC_LAST = PCW'(UC_STEPS - 1);

    typedef enum logic [2:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_SHR,
        OP_DIV
    } t_op;

    typedef enum logic [4:0] {
        R_POS, R_VEL, R_C0, R_C1, R_C2, R_C3,
        R_DT, R_Z, R_ACC, R_Q, R_R,
        R_HD, R_T, R_PX, R_PV, R_A00, R_A01,
        R_P00, R_P01, R_P10, R_P11, R_S, R_K0, R_K1, R_Y
    } t_reg;

    typedef struct packed {
        t_op  op;
        t_reg src_a;
        t_reg src_b;
        t_reg dst;
    } t_uop;

    // Filter program: predict, gain, correct, covariance update
    function automatic t_uop ucode(input logic [PCW-1:0] pc);
        t_uop u;
        case (pc)
            6'd0:  u = '{OP_MUL, R_DT,  R_DT,  R_T};
            6'd1:  u = '{OP_SHR, R_T,   R_T,   R_HD};
            6'd2:  u = '{OP_MUL, R_DT,  R_VEL, R_T};
            6'd3:  u = '{OP_ADD, R_POS, R_T,   R_PX};
            6'd4:  u = '{OP_MUL, R_HD,  R_ACC, R_T};
            6'd5:  u = '{OP_ADD, R_PX,  R_T,   R_PX};
            6'd6:  u = '{OP_MUL, R_DT,  R_ACC, R_T};
            6'd7:  u = '{OP_ADD, R_VEL, R_T,   R_PV};
            6'd8:  u = '{OP_MUL, R_DT,  R_C2,  R_T};
            6'd9:  u = '{OP_ADD, R_C0,  R_T,   R_A00};
            6'd10: u = '{OP_MUL, R_DT,  R_C3,  R_T};
            6'd11: u = '{OP_ADD, R_C1,  R_T,   R_A01};
            6'd12: u = '{OP_MUL, R_DT,  R_A01, R_T};
            6'd13: u = '{OP_ADD, R_A00, R_T,   R_P00};
            6'd14: u = '{OP_ADD, R_P00, R_Q,   R_P00};
            6'd15: u = '{OP_ADD, R_A01, R_Q,   R_P01};
            6'd16: u = '{OP_MUL, R_DT,  R_C3,  R_T};
            6'd17: u = '{OP_ADD, R_C2,  R_T,   R_P10};
            6'd18: u = '{OP_ADD, R_P10, R_Q,   R_P10};
            6'd19: u = '{OP_ADD, R_C3,  R_Q,   R_P11};
            6'd20: u = '{OP_ADD, R_P00, R_R,   R_S};
            6'd21: u = '{OP_DIV, R_P00, R_S,   R_K0};
            6'd22: u = '{OP_DIV, R_P10, R_S,   R_K1};
            6'd23: u = '{OP_SUB, R_Z,   R_PX,  R_Y};
            6'd24: u = '{OP_MUL, R_K0,  R_Y,   R_T};
            6'd25: u = '{OP_ADD, R_PX,  R_T,   R_POS};
            6'd26: u = '{OP_MUL, R_K1,  R_Y,   R_T};
            6'd27: u = '{OP_ADD, R_PV,  R_T,   R_VEL};
            6'd28: u = '{OP_MUL, R_K0,  R_P00, R_T};
            6'd29: u = '{OP_SUB, R_P00, R_T,   R_C0};
            6'd30: u = '{OP_MUL, R_K0,  R_P01, R_T};
            6'd31: u = '{OP_SUB, R_P01, R_T,   R_C1};
            6'd32: u = '{OP_MUL, R_K1,  R_P00, R_T};
            6'd33: u = '{OP_SUB, R_P10, R_T,   R_C2};
            6'd34: u = '{OP_MUL, R_K1,  R_P01, R_T};
            6'd35: u = '{OP_SUB, R_P11, R_T,   R_C3};
            default: u = '{OP_ADD, R_T, R_T, R_T};
        endcase
        return u;
    endfunction

endpackage

### rtl/core/kpvf_alu.sv
module kpvf_alu #(
    parameter int DW = 32,
    parameter int FB = 16
) (
    input  kpvf_pkg::t_op        i_op,
    input  logic signed [DW-1:0] i_a,
    input  logic signed [DW-1:0] i_b,
    output logic signed [DW-1:0] o_y
);

    localparam int PW = 2 * DW + 1;
    localparam logic signed [DW-1:0] FX_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] FX_MIN = {1'b1, {(DW-1){1'b0}}};
    localparam logic [PW-1:0] RND  = PW'(1) << (FB - 1);
    localparam logic [PW-1:0] LIMP = PW'(1) << (DW - 1);

    logic [DW-1:0]   ua, ub;
    logic [PW-1:0]   prod, mag;
    logic            neg;
    logic [DW:0]     sum;
    logic signed [DW-1:0] mul_y, add_y;

    // Fixed-point multiply, round half away from zero, saturate
    always_comb begin
        neg  = i_a[DW-1] ^ i_b[DW-1];
        ua   = i_a[DW-1] ? DW'(-i_a) : DW'(i_a);
        ub   = i_b[DW-1] ? DW'(-i_b) : DW'(i_b);
        prod = PW'(ua) * PW'(ub);
        mag  = (prod + RND) >> FB;
        if (neg) begin
            mul_y = (mag > LIMP) ? FX_MIN : DW'(-mag);
        end else begin
            mul_y = (mag > LIMP - PW'(1)) ? FX_MAX : DW'(mag);
        end
    end

    // Saturating add or subtract
    always_comb begin
        if (i_op == kpvf_pkg::OP_SUB) begin
            sum = {i_a[DW-1], i_a} - {i_b[DW-1], i_b};
        end else begin
            sum = {i_a[DW-1], i_a} + {i_b[DW-1], i_b};
        end
        if (sum[DW] != sum[DW-1]) begin
            add_y = sum[DW] ? FX_MIN : FX_MAX;
        end else begin
            add_y = sum[DW-1:0];
        end
    end

    always_comb begin
        case (i_op)
            kpvf_pkg::OP_MUL: o_y = mul_y;
            kpvf_pkg::OP_SHR: o_y = {i_a[DW-1], i_a[DW-1:1]};
            default:          o_y = add_y;
        endcase
    end

endmodule

### rtl/core/kpvf_div.sv
module kpvf_div #(
    parameter int DW = 32,
    parameter int FB = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [DW-1:0] i_num,
    input  logic signed [DW-1:0] i_den,
    output logic                 o_done,
    output logic signed [DW-1:0] o_quot
);

    localparam int NW = DW + FB;
    localparam int QW = NW + 1;
    localparam int CW = $clog2(NW + 1);
    localparam logic signed [DW-1:0] FX_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] FX_MIN = {1'b1, {(DW-1){1'b0}}};
    localparam logic [QW-1:0] LIMP = QW'(1) << (DW - 1);

    typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIN} t_dstate;

    t_dstate       r_state;
    logic [NW-1:0] r_num, r_quo;
    logic [DW-1:0] r_den, r_rem;
    logic [CW-1:0] r_cnt;
    logic          r_neg;

    logic [DW:0]   rem_sh;
    logic          ge, rnd;
    logic [QW-1:0] q1;
    logic signed [DW-1:0] n_quot;

    // One quotient bit per cycle, restoring
    always_comb begin
        rem_sh = {r_rem, r_num[NW-1]};
        ge     = rem_sh >= {1'b0, r_den};
        rnd    = {r_rem, 1'b0} >= {1'b0, r_den};
        q1     = {1'b0, r_quo} + QW'(rnd);
        if (r_neg) begin
            n_quot = (q1 > LIMP) ? FX_MIN : DW'(-q1);
        end else begin
            n_quot = (q1 > LIMP - QW'(1)) ? FX_MAX : DW'(q1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            o_done  <= 1'b0;
        end else begin
            o_done <= 1'b0;
            case (r_state)
                D_IDLE: begin
                    if (i_start) begin
                        r_neg <= i_num[DW-1] ^ i_den[DW-1];
                        r_num <= {(i_num[DW-1] ? DW'(-i_num) : DW'(i_num)), {FB{1'b0}}};
                        r_den <= i_den[DW-1] ? DW'(-i_den) : DW'(i_den);
                        r_rem <= '0;
                        r_quo <= '0;
                        r_cnt <= CW'(NW);
                        // Zero divisor gives a zero gain
                        if (i_den == '0) begin
                            o_quot <= '0;
                            o_done <= 1'b1;
                        end else begin
                            r_state <= D_RUN;
                        end
                    end
                end
                D_RUN: begin
                    r_rem <= ge ? DW'(rem_sh - {1'b0, r_den}) : rem_sh[DW-1:0];
                    r_quo <= {r_quo[NW-2:0], ge};
                    r_num <= {r_num[NW-2:0], 1'b0};
                    r_cnt <= r_cnt - CW'(1);
                    if (r_cnt == CW'(1)) begin
                        r_state <= D_FIN;
                    end
                end
                D_FIN: begin
                    o_quot  <= n_quot;
                    o_done  <= 1'b1;
                    r_state <= D_IDLE;
                end
                default: r_state <= D_IDLE;
            endcase
        end
    end

endmodule

### rtl/core/kalman_position_velocity_filter.sv
// Channel | Direction | Handshake              | Payload
// input   | in        | i_in_valid / o_in_stall | i_time_step, i_measured_position
// output  | out       | o_out_valid / i_out_stall | o_est_position, o_est_velocity,
//         |           |                        | o_pred_position
// config  | in        | i_cfg_we               | i_cfg_index, i_cfg_data
//
// One transaction runs 36 microcode steps. All but the two division steps pass
// through a shared multiply/add unit; the division steps hold in the bit-serial
// divider, which skips its run and gives a zero quotient when the divisor is zero.
// The result is then offered and waits in the output register until taken; the
// next transaction can be taken only after the result is taken. Input stall stays
// high from accept until the result transaction completes. Reset clears state,
// covariance and loads the register defaults; it is synchronous.
module kalman_position_velocity_filter #(
    parameter int FRAC_BITS  = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [kpvf_pkg::TSW-1:0]     i_time_step,
    input  logic signed [DATA_WIDTH-1:0] i_measured_position,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic signed [DATA_WIDTH-1:0] o_est_position,
    output logic signed [DATA_WIDTH-1:0] o_est_velocity,
    output logic signed [DATA_WIDTH-1:0] o_pred_position,
    input  logic                         i_cfg_we,
    input  logic [1:0]                   i_cfg_index,
    input  logic [DATA_WIDTH-1:0]        i_cfg_data
);

    localparam int DW = DATA_WIDTH;
    localparam logic [DW-1:0]   ACC_RST   = DW'(20) << FRAC_BITS;
    localparam logic [DW-2:0]   NOISE_RST = (DW-1)'(((64'd1 << FRAC_BITS) + 64'd50) / 64'd100);
    localparam logic [1:0]      CFG_ACC   = 2'd0;
    localparam logic [1:0]      CFG_Q     = 2'd1;
    localparam logic [1:0]      CFG_R     = 2'd2;

    typedef enum logic [1:0] {S_IDLE, S_STEP, S_DIV, S_OUT} t_state;

    t_state r_state;
    logic [kpvf_pkg::PCW-1:0] r_pc;
    logic [kpvf_pkg::TSW-1:0] r_dt;
    logic [DW-2:0] r_q, r_r;
    logic signed [DW-1:0] r_acc, r_z;
    logic signed [DW-1:0] r_pos, r_vel, r_c0, r_c1, r_c2, r_c3;
    logic signed [DW-1:0] r_hd, r_t, r_px, r_pv, r_a00, r_a01;
    logic signed [DW-1:0] r_p00, r_p01, r_p10, r_p11, r_s, r_k0, r_k1, r_y;

    kpvf_pkg::t_uop uop;
    logic signed [DW-1:0] opa, opb, alu_y, div_q, n_wdata;
    logic div_start, div_done, n_wen;

    // Pick an operand register
    function automatic logic signed [DW-1:0] pick(input kpvf_pkg::t_reg sel,
        input logic signed [DW-1:0] pos, vel, c0, c1, c2, c3, dt, z, acc, q, r,
        hd, t, px, pv, a00, a01, p00, p01, p10, p11, s, k0, k1, y);
        logic signed [DW-1:0] v;
        case (sel)
            kpvf_pkg::R_POS: v = pos;
            kpvf_pkg::R_VEL: v = vel;
            kpvf_pkg::R_C0:  v = c0;
            kpvf_pkg::R_C1:  v = c1;
            kpvf_pkg::R_C2:  v = c2;
            kpvf_pkg::R_C3:  v = c3;
            kpvf_pkg::R_DT:  v = dt;
            kpvf_pkg::R_Z:   v = z;
            kpvf_pkg::R_ACC: v = acc;
            kpvf_pkg::R_Q:   v = q;
            kpvf_pkg::R_R:   v = r;
            kpvf_pkg::R_HD:  v = hd;
            kpvf_pkg::R_T:   v = t;
            kpvf_pkg::R_PX:  v = px;
            kpvf_pkg::R_PV:  v = pv;
            kpvf_pkg::R_A00: v = a00;
            kpvf_pkg::R_A01: v = a01;
            kpvf_pkg::R_P00: v = p00;
            kpvf_pkg::R_P01: v = p01;
            kpvf_pkg::R_P10: v = p10;
            kpvf_pkg::R_P11: v = p11;
            kpvf_pkg::R_S:   v = s;
            kpvf_pkg::R_K0:  v = k0;
            kpvf_pkg::R_K1:  v = k1;
            default:         v = y;
        endcase
        return v;
    endfunction

    // Decode the current step and fetch operands
    always_comb begin
        uop = kpvf_pkg::ucode(r_pc);
        opa = pick(uop.src_a, r_pos, r_vel, r_c0, r_c1, r_c2, r_c3,
            DW'(r_dt), r_z, r_acc, DW'(r_q), DW'(r_r), r_hd, r_t, r_px, r_pv,
            r_a00, r_a01, r_p00, r_p01, r_p10, r_p11, r_s, r_k0, r_k1, r_y);
        opb = pick(uop.src_b, r_pos, r_vel, r_c0, r_c1, r_c2, r_c3,
            DW'(r_dt), r_z, r_acc, DW'(r_q), DW'(r_r), r_hd, r_t, r_px, r_pv,
            r_a00, r_a01, r_p00, r_p01, r_p10, r_p11, r_s, r_k0, r_k1, r_y);
        div_start = (r_state == S_STEP) && (uop.op == kpvf_pkg::OP_DIV);
        n_wen     = ((r_state == S_STEP) && (uop.op != kpvf_pkg::OP_DIV))
                    || ((r_state == S_DIV) && div_done);
        n_wdata   = (r_state == S_DIV) ? div_q : alu_y;
    end

    kpvf_alu #(.DW(DW), .FB(FRAC_BITS)) u_alu (
        .i_op (uop.op),
        .i_a  (opa),
        .i_b  (opb),
        .o_y  (alu_y)
    );

    kpvf_div #(.DW(DW), .FB(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (opa),
        .i_den   (opb),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_est_position  = r_pos;
    assign o_est_velocity  = r_vel;
    assign o_pred_position = r_px;

    // Sequencer, configuration and working registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pc        <= '0;
            o_out_valid <= 1'b0;
            r_acc       <= ACC_RST;
            r_q         <= NOISE_RST;
            r_r         <= NOISE_RST;
            r_pos       <= '0;
            r_vel       <= '0;
            r_c0        <= '0;
            r_c1        <= '0;
            r_c2        <= '0;
            r_c3        <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_ACC: r_acc <= i_cfg_data;
                    CFG_Q:   r_q   <= i_cfg_data[DW-2:0];
                    CFG_R:   r_r   <= i_cfg_data[DW-2:0];
                    default: ;
                endcase
            end

            if (n_wen) begin
                case (uop.dst)
                    kpvf_pkg::R_POS: r_pos <= n_wdata;
                    kpvf_pkg::R_VEL: r_vel <= n_wdata;
                    kpvf_pkg::R_C0:  r_c0  <= n_wdata;
                    kpvf_pkg::R_C1:  r_c1  <= n_wdata;
                    kpvf_pkg::R_C2:  r_c2  <= n_wdata;
                    kpvf_pkg::R_C3:  r_c3  <= n_wdata;
                    kpvf_pkg::R_HD:  r_hd  <= n_wdata;
                    kpvf_pkg::R_T:   r_t   <= n_wdata;
                    kpvf_pkg::R_PX:  r_px  <= n_wdata;
                    kpvf_pkg::R_PV:  r_pv  <= n_wdata;
                    kpvf_pkg::R_A00: r_a00 <= n_wdata;
                    kpvf_pkg::R_A01: r_a01 <= n_wdata;
                    kpvf_pkg::R_P00: r_p00 <= n_wdata;
                    kpvf_pkg::R_P01: r_p01 <= n_wdata;
                    kpvf_pkg::R_P10: r_p10 <= n_wdata;
                    kpvf_pkg::R_P11: r_p11 <= n_wdata;
                    kpvf_pkg::R_S:   r_s   <= n_wdata;
                    kpvf_pkg::R_K0:  r_k0  <= n_wdata;
                    kpvf_pkg::R_K1:  r_k1  <= n_wdata;
                    kpvf_pkg::R_Y:   r_y   <= n_wdata;
                    default: ;
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_dt    <= i_time_step;
                        r_z     <= i_measured_position;
                        r_pc    <= '0;
                        r_state <= S_STEP;
                    end
                end
                S_STEP: begin
                    if (uop.op == kpvf_pkg::OP_DIV) begin
                        r_state <= S_DIV;
                    end else if (r_pc == kpvf_pkg::UC_LAST) begin
                        o_out_valid <= 1'b1;
                        r_state     <= S_OUT;
                    end else begin
                        r_pc <= r_pc + kpvf_pkg::PCW'(1);
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_pc    <= r_pc + kpvf_pkg::PCW'(1);
                        r_state <= S_STEP;
                    end
                end
                S_OUT: begin
                    // Hold the result until taken
                    if (!i_out_stall) begin
                        o_out_valid <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

### rtl/core/kpvf_chk.sv
`include "assert_macros.svh"

module kpvf_chk #(
    parameter int DATA_WIDTH = 32
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_stall,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input logic [DATA_WIDTH-1:0] o_est_position,
    input logic [DATA_WIDTH-1:0] o_est_velocity,
    input logic [DATA_WIDTH-1:0] o_pred_position
);

    logic [3*DATA_WIDTH-1:0] payload;

    // Gather the result fields
    assign payload = {o_est_position, o_est_velocity, o_pred_position};

    // Result stays offered while stalled
    `KPVF_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid, "result dropped")

    // Stalled result payload does not move
    `KPVF_ASSERT_NEXT(a_out_stable, o_out_valid && i_out_stall, $stable(payload), "payload moved")

    // Busy right after a transaction is taken
    `KPVF_ASSERT_NEXT(a_busy, i_in_valid && !o_in_stall, o_in_stall && !o_out_valid, "not busy")

    // No new input while a result waits
    `KPVF_ASSERT_HOLD(a_one_item, !o_out_valid || o_in_stall, "input open with result pending")

endmodule

bind kalman_position_velocity_filter kpvf_chk #(.DATA_WIDTH(DATA_WIDTH)) u_kpvf_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_est_position  (o_est_position),
    .o_est_velocity  (o_est_velocity),
    .o_pred_position (o_pred_position)
);
